// File: design/ttl_key_value_table_defines.svh
// ============================================================================
// ttl_key_value_table_defines.svh
// Assertion macros used by the key-value table top level.
// ============================================================================
`ifndef TTL_KEY_VALUE_TABLE_DEFINES_SVH
`define TTL_KEY_VALUE_TABLE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define TTL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define TTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// File: design/ttl_pkg.sv
// ============================================================================
// ttl_pkg
// Types, constants and opcodes shared by the key-value table modules.
// ============================================================================
package ttl_pkg;

   // Table capacity and derived widths
   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = IDX_W + 1;
   localparam int LIVE_W  = 5;
   localparam int EXP_W   = 33;

   localparam logic [CNT_W-1:0]  SCAN_LAST = CNT_W'(ENTRIES);
   localparam logic [LIVE_W-1:0] COUNT_MAX = {LIVE_W{1'b1}};

   // Operation codes
   localparam logic [1:0] FUNC_SET   = 2'd0;
   localparam logic [1:0] FUNC_GET   = 2'd1;
   localparam logic [1:0] FUNC_COUNT = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] key;
      logic [31:0] value;
      logic [15:0] duration;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic              existed;
      logic              hit;
      logic [31:0]       value_out;
      logic [LIVE_W-1:0] live_count;
      logic              overflow;
   } rsp_type;

   // One stored slot
   typedef struct packed {
      logic [31:0]      key;
      logic [31:0]      value;
      logic [EXP_W-1:0] expiry;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
      logic rsp_room;
   } status_type;

endpackage

// File: design/ttl_ram.sv
// ============================================================================
// ttl_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ttl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ttl_ctrl.sv
// ============================================================================
// ttl_ctrl
// Request sequencer: accept, scan all slots, then finish and post the response.
// ============================================================================
module ttl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ttl_pkg::status_type status,
   output ttl_pkg::cmd_type    cmd
);

   ttl_pkg::state_type state_ff;
   ttl_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttl_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ttl_pkg::ST_SCAN;
            end
         end
         ttl_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ttl_pkg::ST_FINISH;
            end
         end
         ttl_pkg::ST_FINISH: begin
            if (status.rsp_room) begin
               state_in = ttl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttl_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ttl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ttl_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
         end
         ttl_pkg::ST_FINISH: begin
            cmd.finish = status.rsp_room;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/ttl_datapath.sv
// ============================================================================
// ttl_datapath
// Request register, slot RAM, one-slot-per-cycle scan and response register.
// ============================================================================
module ttl_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ttl_pkg::req_type     req_data,
   output ttl_pkg::rsp_type     rsp_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ttl_pkg::cmd_type     cmd,
   output ttl_pkg::status_type  status
);

   localparam int SLOT_W = $bits(ttl_pkg::slot_type);

   ttl_pkg::req_type            req_ff, req_in;
   logic [ttl_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        chk_vld_ff, chk_vld_in;
   logic [ttl_pkg::IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [ttl_pkg::CNT_W-1:0]   fill_ff, fill_in;
   logic                        match_found_ff, match_found_in;
   logic [ttl_pkg::IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [31:0]                 match_value_ff, match_value_in;
   logic                        free_found_ff, free_found_in;
   logic [ttl_pkg::IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [ttl_pkg::LIVE_W-1:0]  live_cnt_ff, live_cnt_in;
   ttl_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        rd_en;
   logic [SLOT_W-1:0]           rd_data;
   ttl_pkg::slot_type           slot;
   logic                        slot_live;
   logic                        key_hit;
   logic                        wr_en;
   logic [ttl_pkg::IDX_W-1:0]   wr_addr;
   ttl_pkg::slot_type           wr_slot;
   logic                        is_set;
   ttl_pkg::rsp_type            rsp_new;
   logic                        scan_more;

   // Issue one slot read per scan cycle
   assign scan_more = (cnt_ff != ttl_pkg::SCAN_LAST);
   assign rd_en     = cmd.step && scan_more;

   ttl_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (ttl_pkg::ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (SLOT_W'(wr_slot)),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[ttl_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Classify the slot returned by the RAM; slots fill from zero upward
   assign slot      = ttl_pkg::slot_type'(rd_data);
   assign slot_live = chk_vld_ff && ({1'b0, chk_idx_ff} < fill_ff)
                      && (slot.expiry > {1'b0, req_ff.now});
   assign key_hit   = slot_live && (slot.key == req_ff.key);

   // Write back on a set that found its key or a reusable slot
   assign is_set  = (req_ff.func == ttl_pkg::FUNC_SET);
   assign wr_en   = cmd.finish && is_set && (match_found_ff || free_found_ff);
   assign wr_addr = match_found_ff ? match_idx_ff : free_idx_ff;
   always_comb begin
      wr_slot.key    = req_ff.key;
      wr_slot.value  = req_ff.value;
      wr_slot.expiry = {1'b0, req_ff.now} + ttl_pkg::EXP_W'(req_ff.duration);
   end

   // Build the response for the held request
   always_comb begin
      rsp_new = '0;
      case (req_ff.func)
         ttl_pkg::FUNC_SET: begin
            rsp_new.existed  = match_found_ff;
            rsp_new.overflow = !match_found_ff && !free_found_ff;
         end
         ttl_pkg::FUNC_GET: begin
            rsp_new.hit       = match_found_ff;
            rsp_new.value_out = match_found_ff ? match_value_ff : 32'd0;
         end
         ttl_pkg::FUNC_COUNT: begin
            rsp_new.live_count = live_cnt_ff;
         end
         default: begin
            rsp_new = '0;
         end
      endcase
   end

   // Next-state logic of the scan and output registers
   always_comb begin
      req_in         = req_ff;
      cnt_in         = cnt_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = cnt_ff[ttl_pkg::IDX_W-1:0];
      fill_in        = fill_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_value_in = match_value_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      live_cnt_in    = live_cnt_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      // Capture the request and clear the scan results
      if (cmd.load) begin
         req_in         = req_data;
         cnt_in         = '0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         live_cnt_in    = '0;
      end

      // Advance the read pointer
      if (rd_en) begin
         cnt_in     = cnt_ff + 1'b1;
         chk_vld_in = 1'b1;
      end

      // Keep the lowest live match and the lowest reusable slot
      if (key_hit && !match_found_ff) begin
         match_found_in = 1'b1;
         match_idx_in   = chk_idx_ff;
         match_value_in = slot.value;
      end
      if (chk_vld_ff && !slot_live && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = chk_idx_ff;
      end
      if (slot_live && (live_cnt_ff != ttl_pkg::COUNT_MAX)) begin
         live_cnt_in = live_cnt_ff + 1'b1;
      end

      // Grow the fill mark when a never-used slot is taken
      if (wr_en && !match_found_ff && ({1'b0, free_idx_ff} == fill_ff)) begin
         fill_in = fill_ff + 1'b1;
      end

      // Post the response
      if (cmd.finish) begin
         rsp_in       = rsp_new;
         rsp_valid_in = 1'b1;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      chk_idx_ff     <= chk_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_value_ff <= match_value_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      live_cnt_ff    <= live_cnt_in;
      rsp_ff         <= rsp_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.scan_done = cmd.step && !scan_more;
   assign status.rsp_room  = !rsp_valid_ff || rsp_ready;
   assign rsp_data         = rsp_ff;
   assign rsp_valid        = rsp_valid_ff;

endmodule

// File: design/ttl_key_value_table.sv
// ============================================================================
// ttl_key_value_table
// Key-value table with per-entry expiry times, scanned one slot per cycle.
// ============================================================================
// Usage:
//   Requests arrive on req_valid/req_ready with req_data (func, key, value,
//   duration, now). func selects set, get or count; now must not decrease.
//   Each request gives exactly one response on rsp_valid/rsp_ready with
//   rsp_data (existed, hit, value_out, live_count, overflow); fields that do
//   not belong to the operation read zero.
//   After acceptance the slot RAM's single read port visits every slot once;
//   each read is registered before its slot is checked, and a finish step
//   then writes back and posts the result. A new request is taken only
//   after the last one's response has been posted, as the controller
//   returns to idle to take it. req_ready is high only while idle.
//   Stall: the response waits in an output register, so the next request is
//   taken and scanned meanwhile; it only waits at its end for that register.
//   Reset: synchronous, active high; the table reads empty right after reset
//   with no clearing pass, as slots are tracked by a fill mark.
// ============================================================================
`include "ttl_key_value_table_defines.svh"

module ttl_key_value_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttl_pkg::rsp_type rsp_data
);

   ttl_pkg::cmd_type    cmd;
   ttl_pkg::status_type status;

   ttl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ttl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // An accepted request starts its scan at once and blocks further requests
   `TTL_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_valid && req_ready, cmd.step && !req_ready)

   // A response is never posted over one that is still waiting
   `TTL_ASSERT_SAME(a_finish_has_room, clock, reset, cmd.finish, !rsp_valid || rsp_ready)

   // Posting a response raises valid on the next cycle
   `TTL_ASSERT_NEXT(a_finish_posts, clock, reset, cmd.finish, rsp_valid)

endmodule
